[rtl/core/modbus_tcp_response_deframer_macros.svh]
// ----------------------------------------------------------------------------
// Modbus TCP response deframer assertion macros
// Concurrent assertion helpers, empty when built for synthesis.
// ----------------------------------------------------------------------------
`ifndef MODBUS_TCP_RESPONSE_DEFRAMER_MACROS_SVH
`define MODBUS_TCP_RESPONSE_DEFRAMER_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define MTRD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("mtrd assertion failed");
// next-cycle implication
`define MTRD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("mtrd assertion failed");
`else
`define MTRD_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define MTRD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

[rtl/core/mtrd_pkg.sv]
// ----------------------------------------------------------------------------
// Modbus TCP response deframer package
// Status codes, header byte positions and the result bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package mtrd_pkg;

	typedef enum logic [2:0] {
		ST_OK    = 3'd0,
		ST_SHORT = 3'd1,
		ST_BADFN = 3'd2,
		ST_ODD   = 3'd3,
		ST_BIG   = 3'd4,
		ST_HALT  = 3'd5,
		ST_TRUNC = 3'd6
	} status_t;

	localparam logic [7:0]  FN_READ_HOLDING = 8'h03;
	localparam logic [15:0] MIN_LENGTH      = 16'd3;
	localparam logic [16:0] LENGTH_BIAS     = 17'd6;

	localparam int unsigned POS_TID_HI = 0;
	localparam int unsigned POS_TID_LO = 1;
	localparam int unsigned POS_LEN_HI = 4;
	localparam int unsigned POS_LEN_LO = 5;
	localparam int unsigned POS_UNIT   = 6;
	localparam int unsigned POS_FUNC   = 7;
	localparam int unsigned POS_COUNT  = 8;
	localparam int unsigned POS_DATA   = 9;

	typedef struct packed {
		logic        has_result;
		logic        word_valid;
		logic [15:0] reg_value;
		logic [6:0]  reg_index;
		logic        frame_end;
		status_t     status;
		logic [7:0]  unit_id;
		logic [7:0]  function_code;
		logic [15:0] transaction_id;
		logic [7:0]  byte_count;
	} result_t;

endpackage

`default_nettype wire

[rtl/core/mtrd_frame_engine.sv]
// ----------------------------------------------------------------------------
// Modbus TCP response deframer frame engine
// Per-byte frame state update and result formation for one stream byte.
// ----------------------------------------------------------------------------
`default_nettype none

module mtrd_frame_engine
	import mtrd_pkg::*;
#(
	parameter int MAX_FRAME_BYTES = 260,
	parameter int MAX_DATA_BYTES  = 250
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       advance,
	input  wire logic [7:0] rx_byte,
	output result_t         res
);

	localparam int PW = $clog2(MAX_FRAME_BYTES);
	localparam int FTW = $clog2(MAX_FRAME_BYTES + 1);
	localparam int CW = PW + 1;
	localparam int DW = (PW > 8) ? PW : 8;

	logic [PW-1:0]  pos_q, n_pos;
	logic [FTW-1:0] total_q, n_total;
	logic [15:0]    trans_q, n_trans;
	logic [15:0]    len_q, n_len;
	logic [7:0]     unit_q, n_unit;
	logic [7:0]     fn_q, n_fn;
	logic [7:0]     cnt_q, n_cnt;
	logic [7:0]     hold_q, n_hold;
	logic [6:0]     wc_q, n_wc;
	status_t        err_q, n_err;
	logic           halted_q, n_halted;

	logic           halt_now;
	logic           word_out;
	logic           last;
	logic [16:0]    tot_full;
	logic [PW-1:0]  d_pos;
	logic [PW-1:0]  c_pos;
	status_t        st;

	always_comb begin
		n_pos    = pos_q;
		n_total  = total_q;
		n_trans  = trans_q;
		n_len    = len_q;
		n_unit   = unit_q;
		n_fn     = fn_q;
		n_cnt    = cnt_q;
		n_hold   = hold_q;
		n_wc     = wc_q;
		n_err    = err_q;
		n_halted = halted_q;
		halt_now = 1'b0;
		word_out = 1'b0;
		last     = 1'b0;
		st       = ST_OK;
		tot_full = LENGTH_BIAS + {1'b0, len_q};
		d_pos    = pos_q - PW'(POS_DATA);
		c_pos    = pos_q - PW'(POS_COUNT);

		if (pos_q == PW'(POS_TID_HI)) begin
			n_trans = {rx_byte, 8'h00};
			n_len   = '0;
			n_unit  = '0;
			n_fn    = '0;
			n_cnt   = '0;
			n_hold  = '0;
			n_wc    = '0;
			n_err   = ST_OK;
		end else if (pos_q == PW'(POS_TID_LO)) begin
			n_trans[7:0] = rx_byte;
		end else if (pos_q == PW'(POS_LEN_HI)) begin
			n_len[15:8] = rx_byte;
		end else if (pos_q == PW'(POS_LEN_LO)) begin
			n_len[7:0] = rx_byte;
		end else if (pos_q == PW'(POS_UNIT)) begin
			n_unit = rx_byte;
			if (tot_full > 17'(MAX_FRAME_BYTES)) begin
				halt_now = 1'b1;
			end else begin
				n_total = FTW'(tot_full);
				if (len_q < MIN_LENGTH) begin
					n_err = ST_SHORT;
				end
			end
		end else if (pos_q == PW'(POS_FUNC)) begin
			n_fn = rx_byte;
			if (err_q == ST_OK && rx_byte != FN_READ_HOLDING) begin
				n_err = ST_BADFN;
			end
		end else if (pos_q == PW'(POS_COUNT)) begin
			n_cnt = rx_byte;
			if (err_q == ST_OK) begin
				if (rx_byte[0]) begin
					n_err = ST_ODD;
				end else if (rx_byte > 8'(MAX_DATA_BYTES)) begin
					n_err = ST_BIG;
				end
			end
		end else if (pos_q >= PW'(POS_DATA) && err_q == ST_OK) begin
			if (DW'(d_pos) < DW'(cnt_q)) begin
				if (!d_pos[0]) begin
					n_hold = rx_byte;
				end else begin
					word_out = 1'b1;
					n_wc     = wc_q + 7'd1;
				end
			end
		end

		if (halt_now) begin
			n_halted = 1'b1;
			n_pos    = '0;
			st       = ST_HALT;
		end else begin
			last = (pos_q >= PW'(POS_UNIT)) && ((CW'(pos_q) + CW'(1)) >= CW'(n_total));
			if (last) begin
				n_pos = '0;
				st    = n_err;
				if (st == ST_OK && pos_q >= PW'(POS_COUNT) && DW'(c_pos) < DW'(n_cnt)) begin
					st = ST_TRUNC;
				end
			end else begin
				n_pos = pos_q + PW'(1);
			end
		end

		res.has_result     = !halted_q && (halt_now || word_out || last);
		res.word_valid     = word_out;
		res.reg_value      = word_out ? {hold_q, rx_byte} : 16'h0000;
		res.reg_index      = word_out ? wc_q : 7'd0;
		res.frame_end      = halt_now || last;
		res.status         = st;
		res.unit_id        = n_unit;
		res.function_code  = n_fn;
		res.transaction_id = n_trans;
		res.byte_count     = n_cnt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			total_q  <= '0;
			trans_q  <= '0;
			len_q    <= '0;
			unit_q   <= '0;
			fn_q     <= '0;
			cnt_q    <= '0;
			hold_q   <= '0;
			wc_q     <= '0;
			err_q    <= ST_OK;
			halted_q <= 1'b0;
		end else if (advance && !halted_q) begin
			pos_q    <= n_pos;
			total_q  <= n_total;
			trans_q  <= n_trans;
			len_q    <= n_len;
			unit_q   <= n_unit;
			fn_q     <= n_fn;
			cnt_q    <= n_cnt;
			hold_q   <= n_hold;
			wc_q     <= n_wc;
			err_q    <= n_err;
			halted_q <= n_halted;
		end
	end

endmodule

`default_nettype wire

[rtl/core/modbus_tcp_response_deframer.sv]
// Path: any result for a byte held in the input register is loaded into the result
// register when that byte advances into the frame engine, which waits for the result register.
// Throughput: one byte per cycle; the input register is freed whenever the
// result register is empty or its beat is taken in the same cycle.
// Reset: arst_n clears all frame state, the halt flag and both valid bits.
// After an oversize frame the block drops every byte until reset.
// ----------------------------------------------------------------------------
// Modbus TCP response deframer
// Parses MBAP header and read-holding-registers data into register words.
// ----------------------------------------------------------------------------
`default_nettype none

`include "modbus_tcp_response_deframer_macros.svh"

module modbus_tcp_response_deframer
	import mtrd_pkg::*;
#(
	parameter int MAX_FRAME_BYTES = 260,
	parameter int MAX_DATA_BYTES  = 250
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        rx_valid,
	output logic             rx_ready,
	input  wire logic [7:0]  rx_byte,
	output logic             res_valid,
	input  wire logic        res_ready,
	output logic             word_valid,
	output logic [15:0]      reg_value,
	output logic [6:0]       reg_index,
	output logic             frame_end,
	output logic [2:0]       status,
	output logic [7:0]       unit_id,
	output logic [7:0]       function_code,
	output logic [15:0]      transaction_id,
	output logic [7:0]       byte_count
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       valid_s2;
	result_t    res_s2;
	result_t    res_c;
	logic       advance;

	assign advance  = valid_s1 && (!valid_s2 || res_ready);
	assign rx_ready = !valid_s1 || advance;

	mtrd_frame_engine #(
		.MAX_FRAME_BYTES(MAX_FRAME_BYTES),
		.MAX_DATA_BYTES (MAX_DATA_BYTES)
	) u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.advance(advance),
		.rx_byte(byte_s1),
		.res    (res_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			byte_s1  <= '0;
			valid_s2 <= 1'b0;
			res_s2   <= '0;
		end else begin
			if (rx_valid && rx_ready) begin
				valid_s1 <= 1'b1;
				byte_s1  <= rx_byte;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			// load a fresh result or drop the taken beat
			if (advance && res_c.has_result) begin
				valid_s2 <= 1'b1;
				res_s2   <= res_c;
			end else if (res_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	assign res_valid      = valid_s2;
	assign word_valid     = res_s2.word_valid;
	assign reg_value      = res_s2.reg_value;
	assign reg_index      = res_s2.reg_index;
	assign frame_end      = res_s2.frame_end;
	assign status         = res_s2.status;
	assign unit_id        = res_s2.unit_id;
	assign function_code  = res_s2.function_code;
	assign transaction_id = res_s2.transaction_id;
	assign byte_count     = res_s2.byte_count;

	`MTRD_ASSERT_IMP(a_status_only_at_end, clk, arst_n,
		valid_s2 && !res_s2.frame_end, res_s2.status == ST_OK)
	`MTRD_ASSERT_IMP(a_word_frame_clean, clk, arst_n,
		valid_s2 && res_s2.word_valid && res_s2.frame_end,
		res_s2.status == ST_OK || res_s2.status == ST_TRUNC)
	`MTRD_ASSERT_IMP(a_empty_output_ready, clk, arst_n, !valid_s2, rx_ready)
	`MTRD_ASSERT_NEXT(a_result_loads, clk, arst_n, advance && res_c.has_result, valid_s2)

endmodule

`default_nettype wire
